@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the line discipline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/tld_pkg.sv @@
// shared types and constants of the terminal line discipline
package tld_pkg;

  // request operations
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic [2:0] EV_ECHO  = 3'd0;
  localparam logic [2:0] EV_WAKE  = 3'd1;
  localparam logic [2:0] EV_DATA  = 3'd2;
  localparam logic [2:0] EV_EMPTY = 3'd3;
  localparam logic [2:0] EV_EOF   = 3'd4;
  localparam logic [2:0] EV_INTR  = 3'd5;

  // mode flag bit positions
  localparam int FLG_ECHO   = 0;
  localparam int FLG_ECHONL = 1;
  localparam int FLG_CANON  = 2;
  localparam int FLG_SIG    = 3;
  localparam int FLG_BELL   = 4;

  // register indexes and port widths
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_EOL  = 3'd1;
  localparam logic [2:0] REG_EOF  = 3'd2;
  localparam logic [2:0] REG_INTR = 3'd3;
  localparam logic [2:0] REG_BELL = 3'd4;

  // register reset values
  localparam logic [4:0] RST_MODE = 5'd29;
  localparam logic [7:0] RST_EOL  = 8'd10;
  localparam logic [7:0] RST_EOF  = 8'd4;
  localparam logic [7:0] RST_INTR = 8'd3;
  localparam logic [7:0] RST_BELL = 8'd7;

  // characters used by caret echo
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [4:0] flags;
    logic [7:0] eol;
    logic [7:0] eof;
    logic [7:0] intr;
    logic [7:0] bell;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       line_end;
    logic [7:0] data;
    logic [2:0] kind;
  } res_t;

  // ring access request from the sequencer
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } ring_req_t;

  // ring fill status
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

@@ hw/rtl/tld_cfg.sv @@
// configuration register bank behind the apb port
module tld_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tld_pkg::CFG_AW-1:0] paddr,
  input  logic [tld_pkg::CFG_DW-1:0] pwdata,
  output logic [tld_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output tld_pkg::cfg_t             cfg
);

  logic [4:0] flags_r;
  logic [7:0] eol_r;
  logic [7:0] eof_r;
  logic [7:0] intr_r;
  logic [7:0] bell_r;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[tld_pkg::CFG_AW-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= tld_pkg::RST_MODE;
      eol_r   <= tld_pkg::RST_EOL;
      eof_r   <= tld_pkg::RST_EOF;
      intr_r  <= tld_pkg::RST_INTR;
      bell_r  <= tld_pkg::RST_BELL;
    end else if (wr_en) begin
      case (idx)
        tld_pkg::REG_MODE: flags_r <= pwdata[4:0];
        tld_pkg::REG_EOL:  eol_r   <= pwdata[7:0];
        tld_pkg::REG_EOF:  eof_r   <= pwdata[7:0];
        tld_pkg::REG_INTR: intr_r  <= pwdata[7:0];
        tld_pkg::REG_BELL: bell_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      tld_pkg::REG_MODE: prdata = {27'd0, flags_r};
      tld_pkg::REG_EOL:  prdata = {24'd0, eol_r};
      tld_pkg::REG_EOF:  prdata = {24'd0, eof_r};
      tld_pkg::REG_INTR: prdata = {24'd0, intr_r};
      tld_pkg::REG_BELL: prdata = {24'd0, bell_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{flags: flags_r, eol: eol_r, eof: eof_r, intr: intr_r, bell: bell_r};

endmodule

@@ hw/rtl/tld_ring.sv @@
// character ring: synchronous memory with head, tail and fill count
`include "assert_macros.svh"

module tld_ring #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tld_pkg::ring_req_t    req,
  output tld_pkg::ring_stat_t   stat,
  output logic [7:0]            rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_r [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] head_r;
  logic [AW-1:0] tail_r;
  logic [CW-1:0] count_r;

  // memory port: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem_r[tail_r] <= req.wdata;
    end
    if (req.pop) begin
      rdata_r <= mem_r[head_r];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (req.push) begin
        tail_r  <= (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (req.pop) begin
        head_r  <= (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = rdata_r;

  `ASSERT_NEVER(a_push_full, req.push && stat.full, "push into full ring")
  `ASSERT_NEVER(a_pop_empty, req.pop && stat.empty, "pop from empty ring")
  `ASSERT_CLK(a_cnt_up, req.push && !req.pop |=> count_r == $past(count_r) + 1'b1, "count slip")

endmodule

@@ hw/rtl/tld_seq.sv @@
// request sequencer: echo and wake decisions, read classification, result output
`include "assert_macros.svh"

module tld_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  tld_pkg::cfg_t       cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  output tld_pkg::res_t       out_res,
  output logic                out_tlast,
  output tld_pkg::ring_req_t  ring_req,
  input  tld_pkg::ring_stat_t ring_stat,
  input  logic [7:0]          ring_rdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  tld_pkg::res_t res_r [3];
  tld_pkg::res_t res_nxt [3];
  logic [1:0]    nres_r, nres_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          oval_r, oval_nxt;
  tld_pkg::res_t ores_r, ores_nxt;
  logic          olast_r, olast_nxt;

  tld_pkg::res_t rx_res [3];
  logic [1:0]    rx_n;
  tld_pkg::res_t rd_res;
  logic [7:0]    ch;
  logic [7:0]    caret;
  logic          accept;
  logic          canon;
  logic          sig;
  logic          is_eol;
  logic          echo_en;
  logic          ctl_char;
  logic          wake;
  logic          load;
  logic          at_last;

  assign ch        = in_tdata;
  assign canon     = cfg.flags[tld_pkg::FLG_CANON];
  assign sig       = cfg.flags[tld_pkg::FLG_SIG];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  // ring requests at acceptance
  assign ring_req.push  = accept & (in_op == tld_pkg::OP_RECV) & ~ring_stat.full;
  assign ring_req.pop   = accept & (in_op == tld_pkg::OP_READ) & ~ring_stat.empty;
  assign ring_req.wdata = ch;

  // receive: echo and wake decisions
  assign is_eol   = (ch == cfg.eol);
  assign echo_en  = cfg.flags[tld_pkg::FLG_ECHO] | (cfg.flags[tld_pkg::FLG_ECHONL] & is_eol);
  assign ctl_char = ~is_eol & ((ch < tld_pkg::CH_SPACE) | (ch > tld_pkg::CH_TILDE));
  assign wake     = (sig & (ch == cfg.intr)) | ~canon | is_eol | (ch == cfg.eof);

  always_comb begin
    caret = (ch | tld_pkg::CH_AT) & tld_pkg::CH_DEL;
    if (caret == tld_pkg::CH_DEL) begin
      caret = tld_pkg::CH_QMARK;
    end
  end

  // receive result list
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rx_res[i] = '0;
    end
    rx_n = 2'd0;
    if (ring_stat.full) begin
      if (cfg.flags[tld_pkg::FLG_BELL]) begin
        rx_res[0] = '{line_end: 1'b0, data: cfg.bell, kind: tld_pkg::EV_ECHO};
        rx_n      = 2'd1;
      end
    end else begin
      if (echo_en) begin
        if (ctl_char) begin
          rx_res[0] = '{line_end: 1'b0, data: tld_pkg::CH_CARET, kind: tld_pkg::EV_ECHO};
          rx_res[1] = '{line_end: 1'b0, data: caret, kind: tld_pkg::EV_ECHO};
          rx_n      = 2'd2;
        end else begin
          rx_res[0] = '{line_end: 1'b0, data: ch, kind: tld_pkg::EV_ECHO};
          rx_n      = 2'd1;
        end
      end
      if (wake) begin
        rx_res[rx_n] = '{line_end: 1'b0, data: 8'd0, kind: tld_pkg::EV_WAKE};
        rx_n         = rx_n + 2'd1;
      end
    end
  end

  // read classification of the popped character
  always_comb begin
    if (canon && ring_rdata == cfg.eof) begin
      rd_res = '{line_end: 1'b0, data: 8'd0, kind: tld_pkg::EV_EOF};
    end else if (sig && ring_rdata == cfg.intr) begin
      rd_res = '{line_end: 1'b0, data: 8'd0, kind: tld_pkg::EV_INTR};
    end else begin
      rd_res = '{line_end: ~canon | (ring_rdata == cfg.eol), data: ring_rdata,
                 kind: tld_pkg::EV_DATA};
    end
  end

  assign load    = ~oval_r | out_tready;
  assign at_last = (idx_r == nres_r - 2'd1);

  // sequencer and output register
  always_comb begin
    state_nxt = state_r;
    nres_nxt  = nres_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r & ~out_tready;
    ores_nxt  = ores_r;
    olast_nxt = olast_r;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = res_r[i];
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = 2'd0;
          if (in_op == tld_pkg::OP_RECV) begin
            for (int i = 0; i < 3; i++) begin
              res_nxt[i] = rx_res[i];
            end
            nres_nxt  = rx_n;
            state_nxt = (rx_n == 2'd0) ? ST_IDLE : ST_EMIT;
          end else if (ring_stat.empty) begin
            res_nxt[0] = '{line_end: 1'b0, data: 8'd0, kind: tld_pkg::EV_EMPTY};
            nres_nxt   = 2'd1;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        res_nxt[0] = rd_res;
        nres_nxt   = 2'd1;
        idx_nxt    = 2'd0;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          oval_nxt  = 1'b1;
          ores_nxt  = res_r[idx_r];
          olast_nxt = at_last;
          idx_nxt   = idx_r + 2'd1;
          if (at_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nres_r  <= 2'd0;
      idx_r   <= 2'd0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nres_r  <= nres_nxt;
      idx_r   <= idx_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      res_r[i] <= res_nxt[i];
    end
    ores_r  <= ores_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_res    = ores_r;
  assign out_tlast  = olast_r;

  `ASSERT_NEVER(a_emit_none, state_r == ST_EMIT && nres_r == 2'd0, "emit with empty list")
  `ASSERT_NEVER(a_idx_range, state_r == ST_EMIT && idx_r >= nres_r, "result index overrun")

endmodule

@@ hw/rtl/tty_line_discipline.sv @@
// Terminal receive line discipline with a character ring.
// Requests arrive on the in_ stream: in_tuser[0] selects receive (0) or read (1),
// in_tdata carries the received character. Results leave on the out_ stream:
// out_tuser holds the event kind and the line-end flag, out_tdata the character,
// and out_tlast marks the last result of one request. Registers are written
// through the cfg_ apb port (mode flags, end-of-line, end-of-file, interrupt and
// bell characters). The user must change them only while the block is idle;
// the block does not enforce this. One request is handled at a time. A receive
// puts its results into the result list and loads them one by one into the
// output register. A read pops the ring (registered read data), classifies the
// character in the READ state into the result list and then loads it into the
// output register. in_tready returns high once the last result is loaded into
// the output register, so a new request is taken while that result still waits.
// A stalled receiver holds the output register, which holds the sequencer in turn.
// Reset empties the ring (head, tail and count go to zero, no clearing pass),
// restores register defaults and drops any pending result.
module tty_line_discipline #(
  parameter int RING_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] char_code
  input  logic [0:0]                 in_tuser,   // [0] operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] data_value
  output logic [3:0]                 out_tuser,  // [2:0] event_kind, [3] line_end
  output logic                       out_tlast,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tld_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tld_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tld_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  tld_pkg::cfg_t       cfg;
  tld_pkg::ring_req_t  ring_req;
  tld_pkg::ring_stat_t ring_stat;
  tld_pkg::res_t       out_res;
  logic [7:0]          ring_rdata;

  // register bank
  tld_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // character ring
  tld_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .stat  (ring_stat),
    .rdata (ring_rdata)
  );

  // request sequencer
  tld_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res),
    .out_tlast  (out_tlast),
    .ring_req   (ring_req),
    .ring_stat  (ring_stat),
    .ring_rdata (ring_rdata)
  );

  // result packing
  assign out_tdata = out_res.data;
  assign out_tuser = {out_res.line_end, out_res.kind};

endmodule
